[hdl/mexp_pkg.sv]
package mexp_pkg;

  localparam int DEFAULT_OPERAND_WIDTH = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } mexp_state_t;

  // status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

[hdl/mexp_in_if.sv]
interface mexp_in_if import mexp_pkg::*; #(
  parameter int W = DEFAULT_OPERAND_WIDTH
);
  logic         valid;
  logic         ready;
  logic [W-1:0] base;
  logic [W-1:0] exponent;
  logic [W-1:0] modulus;

  modport source (output valid, base, exponent, modulus, input ready);
  modport sink   (input valid, base, exponent, modulus, output ready);
endinterface

[hdl/mexp_out_if.sv]
interface mexp_out_if import mexp_pkg::*; #(
  parameter int W = DEFAULT_OPERAND_WIDTH
);
  logic         valid;
  logic         ready;
  logic [W-1:0] residue;
  logic         zero_modulus;

  modport source (output valid, residue, zero_modulus, input ready);
  modport sink   (input valid, residue, zero_modulus, output ready);
endinterface

[hdl/mexp_mulmod.sv]
module mexp_mulmod import mexp_pkg::*; #(
  parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] x_in,
  input  logic [OPERAND_WIDTH-1:0] y_in,
  input  logic [OPERAND_WIDTH-1:0] m_in,
  output logic [OPERAND_WIDTH-1:0] product,
  output mm_stat_t                 stat
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [W-1:0]  m_r, m_nxt;

  logic [W:0] dbl, red, sum, step;

  // one bit of y per cycle, from the top: acc = 2*acc (+ x) mod m
  always_comb begin
    dbl  = {acc_r, 1'b0};
    red  = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum  = red + {1'b0, x_r};
    step = y_r[W-1] ? ((sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum) : red;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W - 1);
      acc_nxt  = '0;
      x_nxt    = x_in;
      y_nxt    = y_in;
      m_nxt    = m_in;
    end else if (busy_r) begin
      acc_nxt = step[W-1:0];
      y_nxt   = {y_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef ASSERT_OFF
  a_done_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> acc_r < m_r)
    else $error("multiplier product not reduced");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("multiplier started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("multiplier done without a run");
`endif

endmodule

[hdl/modular_exponentiation_unit.sv]
// modular exponentiation, square and multiply; a new item is taken only once the last
// result has gone to the output register; the base is first reduced, then for each
// exponent bit up to the top set bit the square is taken, after a multiply when the bit is
// set, all in one shared bit-serial modular multiplier (W = OPERAND_WIDTH); a zero modulus
// skips the multiplier and answers with residue zero
// reset (synchronous, active low) clears control and valid state only
module modular_exponentiation_unit import mexp_pkg::*; #(
  parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
  input logic          clk,
  input logic          rst_n,
  mexp_in_if.sink      in_chan,
  mexp_out_if.source   out_chan
);

  localparam int W = OPERAND_WIDTH;

  mexp_state_t state_r, state_nxt;
  logic [W-1:0] exp_r, exp_nxt;
  logic [W-1:0] mod_r, mod_nxt;
  logic [W-1:0] res_r, res_nxt;
  logic [W-1:0] sq_r, sq_nxt;
  logic         zmod_r, zmod_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_res_r, out_res_nxt;
  logic         out_zmod_r, out_zmod_nxt;

  logic         mm_start;
  logic [W-1:0] mm_x, mm_y, mm_m, mm_p;
  mm_stat_t     mm_stat;
  logic         in_xfer;
  logic [W-1:0] one_mod;

  mexp_mulmod #(.OPERAND_WIDTH(W)) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .x_in    (mm_x),
    .y_in    (mm_y),
    .m_in    (mm_m),
    .product (mm_p),
    .stat    (mm_stat)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign one_mod       = {{(W-1){1'b0}}, (in_chan.modulus != W'(1))};

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    mod_nxt       = mod_r;
    res_nxt       = res_r;
    sq_nxt        = sq_r;
    zmod_nxt      = zmod_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_res_nxt   = out_res_r;
    out_zmod_nxt  = out_zmod_r;
    mm_start      = 1'b0;
    mm_x          = res_r;
    mm_y          = sq_r;
    mm_m          = mod_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          exp_nxt = in_chan.exponent;
          mod_nxt = in_chan.modulus;
          if (in_chan.modulus == '0) begin
            zmod_nxt  = 1'b1;
            res_nxt   = '0;
            state_nxt = ST_FINISH;
          end else begin
            // base mod m as (1 mod m) * base through the multiplier
            zmod_nxt  = 1'b0;
            res_nxt   = one_mod;
            mm_start  = 1'b1;
            mm_x      = one_mod;
            mm_y      = in_chan.base;
            mm_m      = in_chan.modulus;
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          sq_nxt    = mm_p;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (exp_r == '0) begin
          state_nxt = ST_FINISH;
        end else if (exp_r[0]) begin
          mm_start  = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          mm_start  = 1'b1;
          mm_x      = sq_r;
          state_nxt = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_stat.done) begin
          res_nxt   = mm_p;
          mm_start  = 1'b1;
          mm_x      = sq_r;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_stat.done) begin
          sq_nxt    = mm_p;
          exp_nxt   = {1'b0, exp_r[W-1:1]};
          state_nxt = ST_CHECK;
        end
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_zmod_nxt  = zmod_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    exp_r      <= exp_nxt;
    mod_r      <= mod_nxt;
    res_r      <= res_nxt;
    sq_r       <= sq_nxt;
    zmod_r     <= zmod_nxt;
    out_res_r  <= out_res_nxt;
    out_zmod_r <= out_zmod_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.residue      = out_res_r;
  assign out_chan.zero_modulus = out_zmod_r;

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zmod_r |-> out_res_r == '0)
    else $error("zero modulus result not cleared");

  a_check_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> !mm_stat.busy && !mm_stat.done)
    else $error("multiplier active while deciding next step");

  a_running_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> res_r < mod_r && sq_r < mod_r)
    else $error("running values not reduced");
`endif

endmodule

[test/modular_exponentiation_unit_tb.sv]
module modular_exponentiation_unit_tb;
  import mexp_pkg::*;

  localparam int OPW = DEFAULT_OPERAND_WIDTH;
  localparam int CLK_PERIOD = 10;
  // settle time after draining, so any straggling result is still caught
  localparam int SETTLE_CYCLES = 2400;
  localparam longint TIMEOUT_CYCLES = 3000000;

  typedef logic [OPW-1:0] word_t;
  typedef struct {
    word_t residue;
    logic  zero_modulus;
  } power_result_t;

  logic clk;
  logic rst_n;
  bit idling_on;
  int error_count;
  power_result_t pending_powers[$];

  mexp_in_if  #(.W(OPW)) in_ch ();
  mexp_out_if #(.W(OPW)) out_ch ();

  modular_exponentiation_unit #(.OPERAND_WIDTH(OPW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // right-to-left square and multiply at double width
  function automatic power_result_t predict_power(word_t b, word_t e, word_t m);
    logic [2*OPW-1:0] square;
    logic [2*OPW-1:0] acc;
    logic [2*OPW-1:0] m_wide;
    word_t ebits;
    power_result_t r;
    if (m == '0) begin
      r.residue = '0;
      r.zero_modulus = 1'b1;
      return r;
    end
    m_wide = m;
    square = b % m_wide;
    acc = 1 % m_wide;
    ebits = e;
    while (ebits != '0) begin
      if (ebits[0]) acc = (acc * square) % m_wide;
      ebits = ebits >> 1;
      square = (square * square) % m_wide;
    end
    r.residue = acc[OPW-1:0];
    r.zero_modulus = 1'b0;
    return r;
  endfunction

  function automatic word_t rand_word();
    return word_t'({$urandom(), $urandom()});
  endfunction

  function automatic word_t pick_modulus();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return word_t'(1);
      2:       return word_t'($urandom_range(2, 15));
      3:       return word_t'(1) << $urandom_range(1, OPW - 1);
      4:       return '1;
      5:       return '1 - word_t'($urandom_range(1, 64));
      default: return rand_word();
    endcase
  endfunction

  function automatic word_t pick_base(word_t m);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return word_t'(1);
      2:       return m - word_t'(1);
      3:       return m;
      4:       return '1;
      5:       return word_t'($urandom_range(2, 255));
      default: return rand_word();
    endcase
  endfunction

  // full exponents range over the whole word, short ones stay below 1024
  function automatic word_t pick_exponent(bit full);
    if (full) begin
      case ($urandom_range(0, 9))
        0:       return '0;
        1:       return '1;
        2:       return word_t'(1) << $urandom_range(0, OPW - 1);
        default: return rand_word();
      endcase
    end
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return word_t'(1) << $urandom_range(0, 9);
      default: return word_t'($urandom_range(1, 1023));
    endcase
  endfunction

  // returns at the rising edge of the transfer; valid is left high for the next item
  task automatic send_power(input word_t b, input word_t e, input word_t m);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.base     <= b;
    in_ch.exponent <= e;
    in_ch.modulus  <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_powers.push_back(predict_power(b, e, m));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_powers.size() != 0) @(negedge clk);
  endtask

  task automatic test_special_cases();
    send_power(word_t'(5), word_t'(9), '0);
    send_power('1, '1, '0);
    send_power(word_t'(5), word_t'(7), word_t'(1));
    send_power('1, '0, word_t'(1));
    send_power('0, '0, word_t'(7));
    send_power('1, '0, '1);
    send_power('0, word_t'(5), word_t'(13));
    send_power('1, '1, '1);
    send_power('1, '1, '1 - word_t'(1));
    send_power(word_t'(2), word_t'(10), word_t'(1000));
    send_power(word_t'(100), word_t'(3), word_t'(7));
    send_power(word_t'(7), word_t'(3), word_t'(7));
    send_power('1 - word_t'(5), word_t'(2), '1 - word_t'(4));
    send_power(word_t'(32'h1234_5678), word_t'(1), word_t'(32'h00AB_CDEF));
    send_power(word_t'(3), word_t'(1) << (OPW - 1), '1 - word_t'(4));
    send_power(word_t'(3), '1, word_t'(2));
    // fermat check against a prime modulus, should give one
    send_power(word_t'(2), word_t'(32'hFFFF_FFFA), word_t'(32'hFFFF_FFFB));
    send_power(word_t'(32'hAAAA_AAAA), word_t'(32'h5555_5555), word_t'(32'h8000_0000));
  endtask

  task automatic test_random_powers(input int n, input bit full);
    word_t m;
    for (int i = 0; i < n; i++) begin
      m = pick_modulus();
      send_power(pick_base(m), pick_exponent(full), m);
      // now and then hold off until the block has answered everything
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
  endtask

  task automatic test_steady_stream(input int n);
    word_t m;
    idling_on = 1'b0;
    for (int i = 0; i < n; i++) begin
      m = pick_modulus();
      send_power(pick_base(m), pick_exponent($urandom_range(0, 1) == 1), m);
    end
  endtask

  // result sink with random stall bursts while idling_on is set
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    power_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual residue %h zero_modulus %b",
                 $time, out_ch.residue, out_ch.zero_modulus);
        error_count++;
      end else begin
        want = pending_powers.pop_front();
        if (out_ch.residue !== want.residue) begin
          $display("%0t: residue mismatch, expected %h, actual %h",
                   $time, want.residue, out_ch.residue);
          error_count++;
        end
        if (out_ch.zero_modulus !== want.zero_modulus) begin
          $display("%0t: zero_modulus mismatch, expected %b, actual %b",
                   $time, want.zero_modulus, out_ch.zero_modulus);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    error_count = 0;
    idling_on = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.base = '0;
    in_ch.exponent = '0;
    in_ch.modulus = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_special_cases();
    wait_drained();
    test_random_powers(110, 1'b1);
    wait_drained();
    test_random_powers(110, 1'b0);
    test_steady_stream(40);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/mexp_pkg.sv
hdl/mexp_in_if.sv
hdl/mexp_out_if.sv
hdl/mexp_mulmod.sv
hdl/modular_exponentiation_unit.sv
test/modular_exponentiation_unit_tb.sv
